// ===== rtl/psit_pkg.sv =====
`default_nettype none
package psit_pkg;

	localparam int COORD_BITS = 24;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	localparam int NORM_BITS  = 16;
	localparam int MAG_BITS   = NORM_BITS + 1;
	localparam int CFG_IDX_BITS = 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [NORM_BITS-1:0]  norm_t;
	typedef logic [MAG_BITS-1:0]          nmag_t;
	typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;

	// configuration register indexes
	localparam cfg_idx_t REG_NORMAL_X = 2'd0;
	localparam cfg_idx_t REG_NORMAL_Y = 2'd1;
	localparam cfg_idx_t REG_NORMAL_Z = 2'd2;

	typedef enum logic [1:0] {
		DROP_X,
		DROP_Y,
		DROP_Z
	} drop_t;

	// strict sign of a*b - c*d
	typedef struct packed {
		logic gt;
		logic lt;
	} sign_t;

	// stage enables for one product-compare unit
	typedef struct packed {
		logic mul_en;
		logic cmp_en;
	} sp_ctl_t;

	function automatic diff_t sub(coord_t p, coord_t q);
		return diff_t'(p) - diff_t'(q);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/psit_in_if.sv =====
`default_nettype none
interface psit_in_if;
	logic valid;
	logic ready;
	psit_pkg::coord_t a_x;
	psit_pkg::coord_t a_y;
	psit_pkg::coord_t a_z;
	psit_pkg::coord_t b_x;
	psit_pkg::coord_t b_y;
	psit_pkg::coord_t b_z;
	psit_pkg::coord_t c_x;
	psit_pkg::coord_t c_y;
	psit_pkg::coord_t c_z;
	psit_pkg::coord_t d_x;
	psit_pkg::coord_t d_y;
	psit_pkg::coord_t d_z;

	modport source (
		output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z,
		input  ready
	);
	modport sink (
		input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/psit_out_if.sv =====
`default_nettype none
interface psit_out_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (
		output valid, hit,
		input  ready
	);
	modport sink (
		input  valid, hit,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/psit_sgnprod.sv =====
`default_nettype none
// Sign of a*b - c*d: products in one stage, exact compare in the next.
module psit_sgnprod (
	input  wire                clk,
	input  psit_pkg::sp_ctl_t  ctl,
	input  psit_pkg::diff_t    a,
	input  psit_pkg::diff_t    b,
	input  psit_pkg::diff_t    c,
	input  psit_pkg::diff_t    d,
	output psit_pkg::sign_t    sgn
);
	import psit_pkg::*;

	prod_t p_s3;
	prod_t q_s3;
	sign_t sgn_s4;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			p_s3 <= prod_t'(a) * prod_t'(b);
			q_s3 <= prod_t'(c) * prod_t'(d);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			sgn_s4.gt <= p_s3 > q_s3;
			sgn_s4.lt <= p_s3 < q_s3;
		end
	end

	assign sgn = sgn_s4;
endmodule
`default_nettype wire

// ===== rtl/planar_segment_intersection_test.sv =====
`default_nettype none
// Planar segment intersection test. Each request carries two 3D segments AB
// and CD; the block drops the axis on which the configured plane normal has
// the largest magnitude (ties go to x, then y) and answers with hit = 1 when
// the projected 2D segments touch or cross, end points included. Write the
// normal through cfg_we/cfg_idx/cfg_wdata (index 0 = x, 1 = y, 2 = z) only
// while no request is in flight. One request is taken every cycle unless
// out_ch.ready stalls the pipeline; the answer is driven onto out_ch from the
// result register. The pipeline has five register stages (axis select,
// differences, products, product compare, result), the widest step being a
// 25 x 25 bit signed multiply. All arithmetic is exact, so no input pattern
// can round or overflow. Stalls ripple back stage by stage, so bubbles are
// squeezed out and nothing is lost or repeated.
module planar_segment_intersection_test (
	input  wire                          clk,
	input  wire                          arst_n,
	psit_in_if.sink                      in_ch,
	psit_out_if.source                   out_ch,
	input  wire                          cfg_we,
	input  wire [psit_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  wire [psit_pkg::NORM_BITS-1:0]    cfg_wdata
);
	import psit_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	norm_t normal_x_q, normal_y_q, normal_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_x_q <= '0;
			normal_y_q <= '0;
			normal_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_NORMAL_X: normal_x_q <= norm_t'(cfg_wdata);
				REG_NORMAL_Y: normal_y_q <= norm_t'(cfg_wdata);
				REG_NORMAL_Z: normal_z_q <= norm_t'(cfg_wdata);
				default: ;
			endcase
		end
	end

	function automatic nmag_t nmag(norm_t n);
		nmag_t ext;
		ext = {n[NORM_BITS-1], n};
		return n[NORM_BITS-1] ? (~ext + nmag_t'(1)) : ext;
	endfunction

	// Pick the axis to drop; strict compares keep the earlier axis on a tie.
	nmag_t mag_x, mag_y, mag_z, best;
	drop_t drop;

	always_comb begin
		mag_x = nmag(normal_x_q);
		mag_y = nmag(normal_y_q);
		mag_z = nmag(normal_z_q);
		drop  = DROP_X;
		best  = mag_x;
		if (mag_y > best) begin
			drop = DROP_Y;
			best = mag_y;
		end
		if (mag_z > best)
			drop = DROP_Z;
	end

	// ------------------------------------------------------------------
	// Flow control: a stage advances when it is empty or its successor
	// advances.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic out_valid_q;
	logic adv1, adv2, adv3, adv4, adv5;

	assign adv5 = !out_valid_q || out_ch.ready;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ch.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) v_s1        <= in_ch.valid;
			if (adv2) v_s2        <= v_s1;
			if (adv3) v_s3        <= v_s2;
			if (adv4) v_s4        <= v_s3;
			if (adv5) out_valid_q <= v_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: project onto (u, v) and do the quadrant rejections
	// ------------------------------------------------------------------
	coord_t au, av, bu, bv, cu, cv, du, dv;
	logic   rej;

	function automatic logic pos(coord_t x);
		return !x[COORD_BITS-1] && (x != '0);
	endfunction

	function automatic logic neg(coord_t x);
		return x[COORD_BITS-1];
	endfunction

	always_comb begin
		au = (drop == DROP_X) ? in_ch.a_y : in_ch.a_x;
		bu = (drop == DROP_X) ? in_ch.b_y : in_ch.b_x;
		cu = (drop == DROP_X) ? in_ch.c_y : in_ch.c_x;
		du = (drop == DROP_X) ? in_ch.d_y : in_ch.d_x;
		av = (drop == DROP_Z) ? in_ch.a_y : in_ch.a_z;
		bv = (drop == DROP_Z) ? in_ch.b_y : in_ch.b_z;
		cv = (drop == DROP_Z) ? in_ch.c_y : in_ch.c_z;
		dv = (drop == DROP_Z) ? in_ch.d_y : in_ch.d_z;

		// both ends of AB strictly on one side, both of CD strictly on the other
		rej = (pos(au) && pos(bu) && neg(cu) && neg(du)) ||
		      (neg(au) && neg(bu) && pos(cu) && pos(du)) ||
		      (pos(av) && pos(bv) && neg(cv) && neg(dv)) ||
		      (neg(av) && neg(bv) && pos(cv) && pos(dv));
	end

	coord_t ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1, dx_s1, dy_s1;
	logic   rej_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			ax_s1  <= au;
			ay_s1  <= av;
			bx_s1  <= bu;
			by_s1  <= bv;
			cx_s1  <= cu;
			cy_s1  <= cv;
			dx_s1  <= du;
			dy_s1  <= dv;
			rej_s1 <= rej;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: coordinate differences and the parallel-case overlap
	// ------------------------------------------------------------------
	// Intervals [t1,t2] and [s1,s2] overlap when some t end is <= some s
	// end and some s end is <= some t end.
	function automatic logic overlap(coord_t t1, coord_t t2, coord_t s1, coord_t s2);
		logic ts, st;
		ts = (t1 <= s1) || (t1 <= s2) || (t2 <= s1) || (t2 <= s2);
		st = (s1 <= t1) || (s1 <= t2) || (s2 <= t1) || (s2 <= t2);
		return ts && st;
	endfunction

	diff_t bxa_s2, bya_s2, cxa_s2, cya_s2, dxa_s2, dya_s2, dyc_s2, dxc_s2;
	diff_t axc_s2, ayc_s2, bxc_s2, byc_s2, cxd_s2, cyd_s2;
	logic  rej_s2, ovl_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			bxa_s2 <= sub(bx_s1, ax_s1);
			bya_s2 <= sub(by_s1, ay_s1);
			cxa_s2 <= sub(cx_s1, ax_s1);
			cya_s2 <= sub(cy_s1, ay_s1);
			dxa_s2 <= sub(dx_s1, ax_s1);
			dya_s2 <= sub(dy_s1, ay_s1);
			dyc_s2 <= sub(dy_s1, cy_s1);
			dxc_s2 <= sub(dx_s1, cx_s1);
			axc_s2 <= sub(ax_s1, cx_s1);
			ayc_s2 <= sub(ay_s1, cy_s1);
			bxc_s2 <= sub(bx_s1, cx_s1);
			byc_s2 <= sub(by_s1, cy_s1);
			cxd_s2 <= sub(cx_s1, dx_s1);
			cyd_s2 <= sub(cy_s1, dy_s1);
			rej_s2 <= rej_s1;
			ovl_s2 <= overlap(ax_s1, bx_s1, cx_s1, dx_s1) &&
			          overlap(ay_s1, by_s1, cy_s1, dy_s1);
		end
	end

	// ------------------------------------------------------------------
	// Stages 3 and 4: seven exact product compares
	// ------------------------------------------------------------------
	sp_ctl_t sp_ctl;
	sign_t   cs, ds, as_sg, bs, den, num, rem;

	assign sp_ctl.mul_en = adv3;
	assign sp_ctl.cmp_en = adv4;

	// C and D against line AB
	psit_sgnprod u_cs (.clk(clk), .ctl(sp_ctl),
		.a(bya_s2), .b(cxa_s2), .c(bxa_s2), .d(cya_s2), .sgn(cs));
	psit_sgnprod u_ds (.clk(clk), .ctl(sp_ctl),
		.a(bya_s2), .b(dxa_s2), .c(bxa_s2), .d(dya_s2), .sgn(ds));
	// A and B against line CD
	psit_sgnprod u_as (.clk(clk), .ctl(sp_ctl),
		.a(dyc_s2), .b(axc_s2), .c(dxc_s2), .d(ayc_s2), .sgn(as_sg));
	psit_sgnprod u_bs (.clk(clk), .ctl(sp_ctl),
		.a(dyc_s2), .b(bxc_s2), .c(dxc_s2), .d(byc_s2), .sgn(bs));
	// denominator, numerator and denominator minus numerator of t
	psit_sgnprod u_den (.clk(clk), .ctl(sp_ctl),
		.a(bxa_s2), .b(cyd_s2), .c(cxd_s2), .d(bya_s2), .sgn(den));
	psit_sgnprod u_num (.clk(clk), .ctl(sp_ctl),
		.a(cyd_s2), .b(cxa_s2), .c(cxd_s2), .d(cya_s2), .sgn(num));
	psit_sgnprod u_rem (.clk(clk), .ctl(sp_ctl),
		.a(cyd_s2), .b(bxc_s2), .c(cxd_s2), .d(byc_s2), .sgn(rem));

	// carry the flags alongside the product unit
	logic rej_s3, ovl_s3, rej_s4, ovl_s4;

	always_ff @(posedge clk) begin
		if (adv3) begin
			rej_s3 <= rej_s2;
			ovl_s3 <= ovl_s2;
		end
		if (adv4) begin
			rej_s4 <= rej_s3;
			ovl_s4 <= ovl_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: combine into the result register
	// ------------------------------------------------------------------
	logic cd_same, ab_same, param_ok, hit_d;
	logic hit_q;

	always_comb begin
		// both points strictly on the same side of the other line
		cd_same = (cs.gt && ds.gt) || (cs.lt && ds.lt);
		ab_same = (as_sg.gt && bs.gt) || (as_sg.lt && bs.lt);
		// 0 <= t <= 1 without dividing: signs must agree with the denominator
		if (den.gt)
			param_ok = !num.lt && !rem.lt;
		else
			param_ok = !num.gt && !rem.gt;
		hit_d = !rej_s4 && !cd_same && !ab_same &&
		        ((den.gt || den.lt) ? param_ok : ovl_s4);
	end

	always_ff @(posedge clk) begin
		if (adv5)
			hit_q <= hit_d;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.hit   = hit_q;
endmodule
`default_nettype wire
